// ===== src/tun_pkg.sv =====
package tun_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int OUT_FRAC_BITS = 14;

  // Side information that travels alongside the magnitudes
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } ctl_t;

endpackage

// ===== src/triangle_unit_normal.sv =====
// Unit normal of a triangle: takes three vertices (signed fixed point, CW bits per
// coordinate), forms the edge cross product, its floor integer length and returns each
// component divided by that length, rounded half away from zero, in signed
// Q1.OUT_FRAC_BITS. A flat triangle gives zero components with degenerate set.
// Fully pipelined: one triangle per cycle unless the result side stalls, through a
// bit-per-stage square root and a bit-per-stage divider. A stall on the result
// side holds the whole pipeline.
module triangle_unit_normal #(
  parameter int COORD_WIDTH   = tun_pkg::COORD_WIDTH,
  parameter int OUT_FRAC_BITS = tun_pkg::OUT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] az,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic signed [COORD_WIDTH-1:0] bz,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] cz,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_FRAC_BITS+1:0] nx,
  output logic signed [OUT_FRAC_BITS+1:0] ny,
  output logic signed [OUT_FRAC_BITS+1:0] nz,
  output logic                          degenerate
);

  localparam int MW   = 2 * (COORD_WIDTH + 1);
  localparam int SUMW = 2 * MW + 2;
  localparam int RW   = MW + 1;
  localparam int OW   = OUT_FRAC_BITS + 2;

  logic              en;
  logic              cr_v;
  logic [MW-1:0]     cr_mag [3];
  logic [SUMW-1:0]   cr_sum;
  tun_pkg::ctl_t     cr_ctl;
  logic              sq_v;
  logic [RW-1:0]     sq_root;
  logic [MW-1:0]     sq_mag [3];
  tun_pkg::ctl_t     sq_ctl;
  logic signed [OW-1:0] res [3];

  // Advance everything unless a finished result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tun_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .ax    (ax),
    .ay    (ay),
    .az    (az),
    .bx    (bx),
    .by    (by),
    .bz    (bz),
    .cx    (cx),
    .cy    (cy),
    .cz    (cz),
    .v_out (cr_v),
    .mag   (cr_mag),
    .sum   (cr_sum),
    .ctl   (cr_ctl)
  );

  tun_isqrt #(.CW(COORD_WIDTH)) u_isqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (cr_v),
    .sum    (cr_sum),
    .mag_in (cr_mag),
    .ctl_in (cr_ctl),
    .v_out  (sq_v),
    .root   (sq_root),
    .mag    (sq_mag),
    .ctl    (sq_ctl)
  );

  tun_div #(.CW(COORD_WIDTH), .F(OUT_FRAC_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (sq_v),
    .len    (sq_root),
    .mag    (sq_mag),
    .ctl_in (sq_ctl),
    .v_out  (out_valid),
    .res    (res),
    .degen  (degenerate)
  );

  assign nx = res[0];
  assign ny = res[1];
  assign nz = res[2];

`ifndef SYNTHESIS
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (nx == '0 && ny == '0 && nz == '0))
    else $error("degenerate result with non-zero components");

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nx <= $signed(OW'(1) << OUT_FRAC_BITS)
                && nx >= -$signed(OW'(1) << OUT_FRAC_BITS)
                && ny <= $signed(OW'(1) << OUT_FRAC_BITS)
                && ny >= -$signed(OW'(1) << OUT_FRAC_BITS)
                && nz <= $signed(OW'(1) << OUT_FRAC_BITS)
                && nz >= -$signed(OW'(1) << OUT_FRAC_BITS)))
    else $error("normal component beyond unit range");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(nx) && $stable(ny)
                                   && $stable(nz) && $stable(degenerate)))
    else $error("result changed while stalled");
`endif

endmodule

// ===== src/tun_cross.sv =====
module tun_cross #(
  parameter int CW = tun_pkg::COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] az,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  input  logic signed [CW-1:0] bz,
  input  logic signed [CW-1:0] cx,
  input  logic signed [CW-1:0] cy,
  input  logic signed [CW-1:0] cz,
  output logic                 v_out,
  output logic [2*(CW+1)-1:0]  mag [3],
  output logic [4*(CW+1)+1:0]  sum,
  output tun_pkg::ctl_t        ctl
);

  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int NW   = PW + 1;
  localparam int MW   = PW;
  localparam int SW   = 2 * MW;
  localparam int SUMW = SW + 2;

  logic [5:0] v;

  logic signed [CW-1:0] a_in [3];
  logic signed [CW-1:0] b_in [3];
  logic signed [CW-1:0] c_in [3];

  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] p  [6];
  logic signed [NW-1:0] n  [3];
  logic [MW-1:0]        m4 [3];
  logic [MW-1:0]        m5 [3];
  logic [SW-1:0]        sq [3];
  tun_pkg::ctl_t        ctl4;
  tun_pkg::ctl_t        ctl5;

  assign a_in[0] = ax;
  assign a_in[1] = ay;
  assign a_in[2] = az;
  assign b_in[0] = bx;
  assign b_in[1] = by;
  assign b_in[2] = bz;
  assign c_in[0] = cx;
  assign c_in[1] = cy;
  assign c_in[2] = cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EW'(b_in[i]) - EW'(a_in[i]);
        e2[i] <= EW'(c_in[i]) - EW'(a_in[i]);
      end
      p[0] <= PW'(e1[1]) * PW'(e2[2]);
      p[1] <= PW'(e1[2]) * PW'(e2[1]);
      p[2] <= PW'(e1[2]) * PW'(e2[0]);
      p[3] <= PW'(e1[0]) * PW'(e2[2]);
      p[4] <= PW'(e1[0]) * PW'(e2[1]);
      p[5] <= PW'(e1[1]) * PW'(e2[0]);
      for (int i = 0; i < 3; i++) begin
        n[i] <= NW'(p[2*i]) - NW'(p[2*i+1]);
      end
      for (int i = 0; i < 3; i++) begin
        ctl4.neg[i] <= n[i][NW-1];
        m4[i]       <= n[i][NW-1] ? MW'(-n[i]) : MW'(n[i]);
      end
      ctl4.degen <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SW'(m4[i]) * SW'(m4[i]);
        m5[i] <= m4[i];
        mag[i] <= m5[i];
      end
      ctl5 <= ctl4;
      ctl  <= ctl5;
      sum  <= SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
    end
  end

  assign v_out = v[5];

endmodule

// ===== src/tun_isqrt.sv =====
module tun_isqrt #(
  parameter int CW = tun_pkg::COORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_v,
  input  logic [4*(CW+1)+1:0] sum,
  input  logic [2*(CW+1)-1:0] mag_in [3],
  input  tun_pkg::ctl_t       ctl_in,
  output logic                v_out,
  output logic [2*(CW+1):0]   root,
  output logic [2*(CW+1)-1:0] mag [3],
  output tun_pkg::ctl_t       ctl
);

  localparam int MW   = 2 * (CW + 1);
  localparam int SUMW = 2 * MW + 2;
  localparam int RW   = SUMW / 2;

  logic [RW:0]     v;
  logic [SUMW-1:0] s_q    [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [RW+1:0]   rem_q  [RW+1];
  logic [MW-1:0]   mag_q  [RW+1][3];
  tun_pkg::ctl_t   ctl_q  [RW+1];

  assign v[0]      = in_v;
  assign s_q[0]    = sum;
  assign root_q[0] = '0;
  assign rem_q[0]  = '0;
  assign ctl_q[0]  = ctl_in;
  assign mag_q[0]  = mag_in;

  // One result bit per stage: bring down two bits of the radicand, try root*4+1
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int P = RW - 1 - k;
    logic [RW+2:0] rem_sh;
    logic [RW+2:0] trial;
    logic          ge;

    assign rem_sh = {rem_q[k][RW:0], s_q[k][2*P+1:2*P]};
    assign trial  = {1'b0, root_q[k], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[k+1]    <= s_q[k];
        root_q[k+1] <= {root_q[k][RW-2:0], ge};
        rem_q[k+1]  <= ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
        mag_q[k+1]  <= mag_q[k];
        ctl_q[k+1]  <= ctl_q[k];
      end
    end
  end

  assign v_out = v[RW];
  assign root  = root_q[RW];
  assign mag   = mag_q[RW];
  assign ctl   = ctl_q[RW];

endmodule

// ===== src/tun_div.sv =====
module tun_div #(
  parameter int CW = tun_pkg::COORD_WIDTH,
  parameter int F  = tun_pkg::OUT_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [2*(CW+1):0]          len,
  input  logic [2*(CW+1)-1:0]        mag [3],
  input  tun_pkg::ctl_t              ctl_in,
  output logic                       v_out,
  output logic signed [F+1:0]        res [3],
  output logic                       degen
);

  localparam int MW = 2 * (CW + 1);
  localparam int RW = MW + 1;
  localparam int QW = F + 1;
  localparam int OW = F + 2;

  logic [F+1:0]  v;
  logic [RW-1:0] len_q [F+2];
  logic [RW-1:0] rem_q [F+2][3];
  logic [QW-1:0] q_q   [F+2][3];
  tun_pkg::ctl_t ctl_q [F+2];

  assign v[0]     = in_v;
  assign len_q[0] = len;
  assign ctl_q[0] = ctl_in;
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign rem_q[0][i] = RW'(mag[i]);
    assign q_q[0][i]   = '0;
  end

  // Integer bit first (magnitude never exceeds the length), then one fraction bit per stage
  for (genvar k = 0; k <= F; k++) begin : g_stage
    logic [RW:0] rem_sh [3];
    logic [2:0]  ge;

    for (genvar i = 0; i < 3; i++) begin : g_lane
      if (k == 0) begin : g_first
        assign rem_sh[i] = {1'b0, rem_q[k][i]};
      end else begin : g_rest
        assign rem_sh[i] = {rem_q[k][i], 1'b0};
      end
      assign ge[i] = rem_sh[i] >= {1'b0, len_q[k]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1][i] <= ge[i] ? RW'(rem_sh[i] - {1'b0, len_q[k]}) : RW'(rem_sh[i]);
          q_q[k+1][i]   <= {q_q[k][i][QW-2:0], ge[i]};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_q[k+1] <= len_q[k];
        ctl_q[k+1] <= ctl_q[k];
      end
    end
  end

  logic          v_fin;
  logic [QW-1:0] qr [3];

  // Round half away from zero, restore sign, force zero for a flat triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qr[i] = q_q[F+1][i]
            + QW'({rem_q[F+1][i], 1'b0} >= {1'b0, len_q[F+1]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_fin <= 1'b0;
    end else if (en) begin
      v_fin <= v[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (ctl_q[F+1].degen) begin
          res[i] <= '0;
        end else if (ctl_q[F+1].neg[i]) begin
          res[i] <= -OW'(qr[i]);
        end else begin
          res[i] <= OW'(qr[i]);
        end
      end
      degen <= ctl_q[F+1].degen;
    end
  end

  assign v_out = v_fin;

endmodule
